FILE: rtl/elsm_pkg.sv
// elsm_pkg: shared types, constants and the parent-group table of the
// event latency statistics monitor. No dependencies.
package elsm_pkg;

  // default configuration of the monitor
  localparam int unsigned DEF_NUM_KINDS       = 36;
  localparam int unsigned DEF_NUM_BUCKETS     = 7;
  localparam int unsigned DEF_NUM_GROUP_KINDS = 5;
  localparam int unsigned DEF_LATENCY_WIDTH   = 32;

  // configuration port
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned NUM_BOUNDS = 6;

  localparam logic [2:0] REG_DETAILED_MODE = 3'd0;
  localparam logic [2:0] REG_BOUND_0       = 3'd1;
  localparam logic [2:0] REG_BOUND_5       = 3'd6;

  localparam logic [31:0] BOUND_RESET [NUM_BOUNDS] = '{
    32'd4096, 32'd8192, 32'd16384, 32'd65536, 32'd131072, 32'd262144
  };

  // request commands
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // result groups
  localparam logic [1:0] GRP_READ_HIST  = 2'd0;
  localparam logic [1:0] GRP_WRITE_HIST = 2'd1;
  localparam logic [1:0] GRP_OP_COUNT   = 2'd2;

  // special kinds
  localparam logic [7:0] KIND_READ  = 8'd3;
  localparam logic [7:0] KIND_WRITE = 8'd4;
  localparam logic [7:0] NO_PARENT  = 8'hFF;

  localparam logic [7:0] PARENT_ROM [64] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd0, 8'd3, 8'd4, 8'd2,
    8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'd1, 8'd0, 8'd0, 8'd1,
    8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECORD,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic        command;
    logic [5:0]  event_kind;
    logic [31:0] latency_ticks;
    logic [63:0] byte_count;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  entry_group;
    logic [5:0]  entry_index;
    logic [31:0] entry_count;
    logic [63:0] entry_bytes;
    logic [63:0] entry_latency_sum;
    logic [31:0] entry_latency_min;
    logic [31:0] entry_latency_max;
    logic        has_latency;
    logic        last_entry;
  } result_t;

endpackage

FILE: rtl/event_latency_stats_monitor.sv
// event_latency_stats_monitor: double-banked per-kind latency and size statistics.
// Depends on elsm_pkg and elsm_ram.
//
//   channel   handshake                    payload
//   request   start in, busy out           cmd_i (cmd_t)
//   result    result_valid_o strobe out    result_o (result_t)
//   config    psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// a record request of a known kind keeps busy high through one read-modify-write
// slot each for the kind, its parent group and its histogram bucket, through the
// single read and single write port of the statistics ram; an unknown kind is dropped
// and never raises busy.
// a report request keeps busy high through one ram read per reported entry; each
// result passes the ram read and result registers, results one per cycle.
// reset empties both banks at once through per-entry valid flops.
// results cannot be stalled; the strobe lasts exactly one cycle.
module event_latency_stats_monitor import elsm_pkg::*; #(
  parameter int unsigned NUM_KINDS       = DEF_NUM_KINDS,
  parameter int unsigned NUM_BUCKETS     = DEF_NUM_BUCKETS,
  parameter int unsigned NUM_GROUP_KINDS = DEF_NUM_GROUP_KINDS,
  parameter int unsigned LATENCY_WIDTH   = DEF_LATENCY_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd_i,
  output logic              result_valid_o,
  output result_t           result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned ENTRIES  = NUM_KINDS + 2 * NUM_BUCKETS;
  localparam int unsigned DEPTH    = 2 * ENTRIES;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned EW       = $clog2(ENTRIES);
  localparam int unsigned MAX_RES  = 2 * NUM_BUCKETS + NUM_KINDS;
  localparam int unsigned CNT_W    = $clog2(MAX_RES + 1);
  localparam int unsigned NK_SUM   = (NUM_GROUP_KINDS < NUM_KINDS) ? NUM_GROUP_KINDS : NUM_KINDS;
  localparam int unsigned NB_CMP   = (NUM_BUCKETS - 1 < NUM_BOUNDS) ? NUM_BUCKETS - 1 : NUM_BOUNDS;
  localparam int unsigned LW       = LATENCY_WIDTH;
  localparam int unsigned OFF_BYTES = 32;
  localparam int unsigned OFF_SUM   = 96;
  localparam int unsigned OFF_MIN   = 160;
  localparam int unsigned OFF_MAX   = 160 + LW;
  localparam int unsigned DATA_W    = 160 + 2 * LW;

  localparam logic [CNT_W-1:0] STEP_KIND   = CNT_W'(0);
  localparam logic [CNT_W-1:0] STEP_PARENT = CNT_W'(1);
  localparam logic [CNT_W-1:0] STEP_HIST   = CNT_W'(2);
  localparam logic [CNT_W-1:0] STEP_DONE   = CNT_W'(3);

  // configuration registers
  logic        detailed_q;
  logic [31:0] bound_q [NUM_BOUNDS];
  logic [2:0]  cfg_idx;
  logic        cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detailed_q <= 1'b0;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        bound_q[i] <= BOUND_RESET[i];
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DETAILED_MODE: detailed_q <= pwdata[0];
        default: begin
          if (cfg_idx inside {[REG_BOUND_0:REG_BOUND_5]}) begin
            bound_q[3'(cfg_idx - REG_BOUND_0)] <= pwdata;
          end
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_DETAILED_MODE: prdata = {31'd0, detailed_q};
      default: begin
        if (cfg_idx inside {[REG_BOUND_0:REG_BOUND_5]}) begin
          prdata = bound_q[3'(cfg_idx - REG_BOUND_0)];
        end
      end
    endcase
  end

  // control and request registers
  state_e             state_q, state_d;
  logic               active_bank_q, active_bank_d;
  logic               op_bank_q, op_bank_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [5:0]         kind_q, kind_d;
  logic [LW-1:0]      lat_q, lat_d;
  logic [63:0]        bytes_q, bytes_d;
  logic [DEPTH-1:0]   valid_q, valid_d;

  // read-modify-write / emit stage
  logic               wr_q, wr_d;
  logic               emit_q, emit_d;
  logic [ADDR_W-1:0]  pend_addr_q, pend_addr_d;
  logic               pend_vld_q, pend_vld_d;
  logic [1:0]         pend_group_q, pend_group_d;
  logic [5:0]         pend_index_q, pend_index_d;
  logic               pend_last_q, pend_last_d;

  logic               res_valid_q, res_valid_d;
  result_t            res_q, res_d;

  // ram
  logic               mem_re, mem_we;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [DATA_W-1:0]  mem_wdata, mem_rdata;

  elsm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pend_addr_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // record decode from the latched request
  logic [7:0]       parent;
  logic             parent_ok;
  logic             hist_rd, hist_wr;
  logic [2:0]       bucket;
  logic [EW-1:0]    hist_entry;
  logic [CNT_W-1:0] total;
  logic [79:0]      lat_wide;

  assign parent    = PARENT_ROM[kind_q];
  assign parent_ok = (parent != NO_PARENT) && (parent < 8'(NUM_KINDS));
  assign hist_rd   = ({2'b00, kind_q} == KIND_READ) || (parent == KIND_READ);
  assign hist_wr   = ({2'b00, kind_q} == KIND_WRITE) || (parent == KIND_WRITE);
  assign total     = CNT_W'(2 * NUM_BUCKETS) + (detailed_q ? CNT_W'(NUM_KINDS) : CNT_W'(NK_SUM));
  assign lat_wide  = {48'd0, cmd_i.latency_ticks};

  always_comb begin
    bucket = 3'(NUM_BUCKETS - 1);
    for (int i = NB_CMP - 1; i >= 0; i--) begin
      if (bytes_q < {32'd0, bound_q[i]}) begin
        bucket = 3'(i);
      end
    end
  end

  assign hist_entry = EW'(NUM_KINDS) + (hist_rd ? EW'(0) : EW'(NUM_BUCKETS)) + EW'(bucket);

  // old entry contents, empty if never written since the last clear
  logic [31:0]   old_cnt;
  logic [63:0]   old_bytes, old_sum;
  logic [LW-1:0] old_min, old_max;
  logic [LW-1:0] new_min, new_max;
  logic [LW+31:0] min_wide, max_wide;

  always_comb begin
    if (pend_vld_q) begin
      old_cnt   = mem_rdata[31:0];
      old_bytes = mem_rdata[OFF_BYTES +: 64];
      old_sum   = mem_rdata[OFF_SUM +: 64];
      old_min   = mem_rdata[OFF_MIN +: LW];
      old_max   = mem_rdata[OFF_MAX +: LW];
    end else begin
      old_cnt   = '0;
      old_bytes = '0;
      old_sum   = '0;
      old_min   = '1;
      old_max   = '0;
    end
  end

  assign new_min   = (lat_q < old_min) ? lat_q : old_min;
  assign new_max   = (lat_q > old_max) ? lat_q : old_max;
  assign mem_wdata = {new_max, new_min, old_sum + 64'(lat_q), old_bytes + bytes_q,
                      old_cnt + 32'd1};
  assign mem_we    = wr_q;
  assign min_wide  = {32'd0, old_min};
  assign max_wide  = {32'd0, old_max};

  always_comb begin
    logic          issue;
    logic [EW-1:0] entry;

    state_d       = state_q;
    active_bank_d = active_bank_q;
    op_bank_d     = op_bank_q;
    cnt_d         = cnt_q;
    kind_d        = kind_q;
    lat_d         = lat_q;
    bytes_d       = bytes_q;
    valid_d       = valid_q;
    wr_d          = 1'b0;
    emit_d        = 1'b0;
    pend_group_d  = pend_group_q;
    pend_index_d  = pend_index_q;
    pend_last_d   = 1'b0;
    issue         = 1'b0;
    entry         = '0;

    // write stage of the previous read
    if (wr_q) begin
      valid_d[pend_addr_q] = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          kind_d    = cmd_i.event_kind;
          lat_d     = lat_wide[LW-1:0];
          bytes_d   = cmd_i.byte_count;
          op_bank_d = active_bank_q;
          cnt_d     = '0;
          if (cmd_i.command == CMD_REPORT) begin
            active_bank_d = ~active_bank_q;
            state_d       = ST_REPORT;
          end else if ({1'b0, cmd_i.event_kind} < 7'(NUM_KINDS)) begin
            state_d = ST_RECORD;
          end
        end
      end
      ST_RECORD: begin
        case (cnt_q)
          STEP_KIND: begin
            issue = 1'b1;
            entry = EW'(kind_q);
          end
          STEP_PARENT: begin
            issue = parent_ok;
            entry = EW'(parent);
          end
          STEP_HIST: begin
            issue = hist_rd || hist_wr;
            entry = hist_entry;
          end
          default: begin
            issue = 1'b0;
          end
        endcase
        wr_d  = issue;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == STEP_DONE) begin
          state_d = ST_IDLE;
        end
      end
      ST_REPORT: begin
        issue  = 1'b1;
        emit_d = 1'b1;
        if (cnt_q < CNT_W'(NUM_BUCKETS)) begin
          pend_group_d = GRP_READ_HIST;
          pend_index_d = 6'(cnt_q);
          entry        = EW'(NUM_KINDS) + EW'(cnt_q);
        end else if (cnt_q < CNT_W'(2 * NUM_BUCKETS)) begin
          pend_group_d = GRP_WRITE_HIST;
          pend_index_d = 6'(cnt_q - CNT_W'(NUM_BUCKETS));
          entry        = EW'(NUM_KINDS) + EW'(cnt_q);
        end else begin
          pend_group_d = GRP_OP_COUNT;
          pend_index_d = 6'(cnt_q - CNT_W'(2 * NUM_BUCKETS));
          entry        = EW'(cnt_q - CNT_W'(2 * NUM_BUCKETS));
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == total - CNT_W'(1)) begin
          pend_last_d = 1'b1;
          state_d     = ST_IDLE;
          // the whole finished bank goes empty, reported or not
          for (int e = 0; e < ENTRIES; e++) begin
            if (op_bank_q) begin
              valid_d[ENTRIES + e] = 1'b0;
            end else begin
              valid_d[e] = 1'b0;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    mem_re      = issue;
    mem_raddr   = ADDR_W'(entry) + (op_bank_q ? ADDR_W'(ENTRIES) : ADDR_W'(0));
    pend_addr_d = mem_raddr;
    pend_vld_d  = valid_q[mem_raddr];

    // result register
    res_valid_d                = emit_q;
    res_d                      = res_q;
    if (emit_q) begin
      res_d.entry_group        = pend_group_q;
      res_d.entry_index        = pend_index_q;
      res_d.entry_count        = old_cnt;
      res_d.entry_bytes        = old_bytes;
      res_d.entry_latency_sum  = old_sum;
      res_d.entry_latency_min  = min_wide[31:0];
      res_d.entry_latency_max  = max_wide[31:0];
      res_d.has_latency        = (old_min <= old_max);
      res_d.last_entry         = pend_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      active_bank_q <= 1'b0;
      op_bank_q     <= 1'b0;
      cnt_q         <= '0;
      valid_q       <= '0;
      wr_q          <= 1'b0;
      emit_q        <= 1'b0;
      pend_last_q   <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      active_bank_q <= active_bank_d;
      op_bank_q     <= op_bank_d;
      cnt_q         <= cnt_d;
      valid_q       <= valid_d;
      wr_q          <= wr_d;
      emit_q        <= emit_d;
      pend_last_q   <= pend_last_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    lat_q        <= lat_d;
    bytes_q      <= bytes_d;
    pend_addr_q  <= pend_addr_d;
    pend_vld_q   <= pend_vld_d;
    pend_group_q <= pend_group_d;
    pend_index_q <= pend_index_d;
    res_q        <= res_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

FILE: rtl/elsm_ram.sv
// elsm_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module elsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sim/elsm_checker.sv
// elsm_checker: watches the request, result and register channels of the
// statistics monitor, keeps its own banked statistics and checks every entry.
// Depends on elsm_pkg.
`timescale 1ns / 1ps

module elsm_checker import elsm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  cmd_t              cmd_i,
  input  logic              result_valid_o,
  input  result_t           result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                errors_o,
  output int                waiting_o,
  output int                records_o,
  output int                reports_o,
  output int                entries_o,
  output int                writes_o
);

  localparam int KINDS      = DEF_NUM_KINDS;
  localparam int BUCKETS    = DEF_NUM_BUCKETS;
  localparam int SLOTS      = KINDS + 2 * BUCKETS;
  localparam int READ_BASE  = KINDS;
  localparam int WRITE_BASE = KINDS + BUCKETS;
  localparam int MAX_LINES  = 40;

  logic        detailed;
  logic [31:0] bound [NUM_BOUNDS];
  logic        live_bank;
  logic [31:0] ev_count [2][SLOTS];
  logic [63:0] ev_bytes [2][SLOTS];
  logic [63:0] lat_sum  [2][SLOTS];
  logic [31:0] lat_min  [2][SLOTS];
  logic [31:0] lat_max  [2][SLOTS];
  result_t     entries_due [$];

  task automatic log_mismatch(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    if (errors_o < MAX_LINES) begin
      $display("mismatch at entry %0d: %s expected %0h got %0h", entries_o, what, want, got);
    end
    errors_o++;
  endtask

  task automatic wipe(input logic b, input int e);
    ev_count[b][e] = '0;
    ev_bytes[b][e] = '0;
    lat_sum[b][e]  = '0;
    lat_min[b][e]  = '1;
    lat_max[b][e]  = '0;
  endtask

  task automatic tally(input logic b, input int e, input logic [31:0] lat,
                       input logic [63:0] nbytes);
    ev_count[b][e] = ev_count[b][e] + 32'd1;
    ev_bytes[b][e] = ev_bytes[b][e] + nbytes;
    lat_sum[b][e]  = lat_sum[b][e] + {32'd0, lat};
    if (lat < lat_min[b][e]) lat_min[b][e] = lat;
    if (lat > lat_max[b][e]) lat_max[b][e] = lat;
  endtask

  // first bucket whose bound exceeds the size, else the last one
  function automatic int bucket_for(input logic [63:0] nbytes);
    int pick;
    int i;
    pick = BUCKETS - 1;
    for (i = BUCKETS - 2; i >= 0; i--) begin
      if (i < NUM_BOUNDS && nbytes < {32'd0, bound[i]}) pick = i;
    end
    return pick;
  endfunction

  task automatic note_record(input cmd_t c);
    logic [7:0] parent;
    int         kind;
    int         hist;
    kind = c.event_kind;
    if (kind < KINDS) begin
      parent = PARENT_ROM[kind];
      tally(live_bank, kind, c.latency_ticks, c.byte_count);
      if (parent != NO_PARENT && parent < KINDS) begin
        tally(live_bank, parent, c.latency_ticks, c.byte_count);
      end
      hist = -1;
      if (kind == KIND_READ || parent == KIND_READ) begin
        hist = READ_BASE + bucket_for(c.byte_count);
      end else if (kind == KIND_WRITE || parent == KIND_WRITE) begin
        hist = WRITE_BASE + bucket_for(c.byte_count);
      end
      if (hist >= 0) tally(live_bank, hist, c.latency_ticks, c.byte_count);
    end
  endtask

  task automatic queue_entry(input logic b, input logic [1:0] grp, input int idx,
                             input int e, input logic last);
    result_t r;
    r.entry_group       = grp;
    r.entry_index       = idx[5:0];
    r.entry_count       = ev_count[b][e];
    r.entry_bytes       = ev_bytes[b][e];
    r.entry_latency_sum = lat_sum[b][e];
    r.entry_latency_min = lat_min[b][e];
    r.entry_latency_max = lat_max[b][e];
    r.has_latency       = (lat_min[b][e] <= lat_max[b][e]);
    r.last_entry        = last;
    entries_due.push_back(r);
  endtask

  // swap banks, then stream and clear the finished one
  task automatic note_report();
    logic fin;
    int   shown;
    int   total;
    int   k;
    int   g;
    int   i;
    fin = live_bank;
    shown = detailed ? KINDS : DEF_NUM_GROUP_KINDS;
    if (shown > KINDS) shown = KINDS;
    total = 2 * BUCKETS + shown;
    live_bank = ~fin;
    k = 0;
    for (g = 0; g < 2; g++) begin
      for (i = 0; i < BUCKETS; i++) begin
        queue_entry(fin, (g == 0) ? GRP_READ_HIST : GRP_WRITE_HIST, i,
                    READ_BASE + g * BUCKETS + i, (k + 1) == total);
        k++;
      end
    end
    for (i = 0; i < shown; i++) begin
      queue_entry(fin, GRP_OP_COUNT, i, i, (k + 1) == total);
      k++;
    end
    for (i = 0; i < SLOTS; i++) wipe(fin, i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    int      idx;
    int      i;
    if (!rst_ni) begin
      detailed  = 1'b0;
      for (i = 0; i < NUM_BOUNDS; i++) bound[i] = BOUND_RESET[i];
      live_bank = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
        wipe(1'b0, i);
        wipe(1'b1, i);
      end
      entries_due.delete();
      errors_o  = 0;
      records_o = 0;
      reports_o = 0;
      entries_o = 0;
      writes_o  = 0;
    end else begin
      if (result_valid_o === 1'b1) begin
        if (entries_due.size() == 0) begin
          log_mismatch("entry with nothing expected, index", '0, result_o.entry_index);
        end else begin
          want = entries_due.pop_front();
          if (result_o.entry_group !== want.entry_group)
            log_mismatch("entry_group", want.entry_group, result_o.entry_group);
          if (result_o.entry_index !== want.entry_index)
            log_mismatch("entry_index", want.entry_index, result_o.entry_index);
          if (result_o.entry_count !== want.entry_count)
            log_mismatch("entry_count", want.entry_count, result_o.entry_count);
          if (result_o.entry_bytes !== want.entry_bytes)
            log_mismatch("entry_bytes", want.entry_bytes, result_o.entry_bytes);
          if (result_o.entry_latency_sum !== want.entry_latency_sum)
            log_mismatch("entry_latency_sum", want.entry_latency_sum,
                         result_o.entry_latency_sum);
          if (result_o.entry_latency_min !== want.entry_latency_min)
            log_mismatch("entry_latency_min", want.entry_latency_min,
                         result_o.entry_latency_min);
          if (result_o.entry_latency_max !== want.entry_latency_max)
            log_mismatch("entry_latency_max", want.entry_latency_max,
                         result_o.entry_latency_max);
          if (result_o.has_latency !== want.has_latency)
            log_mismatch("has_latency", want.has_latency, result_o.has_latency);
          if (result_o.last_entry !== want.last_entry)
            log_mismatch("last_entry", want.last_entry, result_o.last_entry);
        end
        entries_o++;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (cmd_i.command == CMD_REPORT) begin
          note_report();
          reports_o++;
        end else begin
          note_record(cmd_i);
          records_o++;
        end
      end
      if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1) begin
        idx = paddr[CFG_AW-1:2];
        if (pwrite === 1'b1) begin
          writes_o++;
          if (idx == REG_DETAILED_MODE) begin
            detailed = pwdata[0];
          end else if (idx >= REG_BOUND_0 && idx <= REG_BOUND_5) begin
            bound[idx - REG_BOUND_0] = pwdata;
          end
        end else if (idx == REG_DETAILED_MODE) begin
          if (prdata !== {31'd0, detailed})
            log_mismatch("detailed_mode readback", {31'd0, detailed}, prdata);
        end else if (idx >= REG_BOUND_0 && idx <= REG_BOUND_5) begin
          if (prdata !== bound[idx - REG_BOUND_0])
            log_mismatch("bucket bound readback", bound[idx - REG_BOUND_0], prdata);
        end
      end
    end
    waiting_o = entries_due.size();
  end

endmodule

FILE: sim/event_latency_stats_monitor_test.sv
// event_latency_stats_monitor_test: drives record and report requests and
// register traffic into the monitor; elsm_checker predicts and compares.
// Depends on elsm_pkg, elsm_checker and the monitor rtl.
`timescale 1ns / 1ps

module event_latency_stats_monitor_test;
  import elsm_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE      = 16;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 26;
  localparam int REG_SPARE   = 7;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  cmd_t              cmd_i;
  logic              result_valid_o;
  result_t           result_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int          errors;
  int          waiting;
  int          n_records;
  int          n_reports;
  int          n_entries;
  int          n_writes;
  logic        calm;
  logic [31:0] cur_bound [NUM_BOUNDS];

  event_latency_stats_monitor uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  elsm_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .errors_o       (errors),
    .waiting_o      (waiting),
    .records_o      (n_records),
    .reports_o      (n_reports),
    .entries_o      (n_entries),
    .writes_o       (n_writes)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // a setup and an access phase, entered and left at a falling edge,
  // then an idle phase on the port
  task automatic reg_access(input logic wr, input int idx, input logic [31:0] data);
    logic [CFG_AW-1:0] addr;
    addr = CFG_AW'(idx * 4);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    if (wr && idx >= REG_BOUND_0 && idx <= REG_BOUND_5) cur_bound[idx - REG_BOUND_0] = data;
  endtask

  // start stays high after the request unless a gap follows
  task automatic issue(input cmd_t c);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  task automatic record(input int kind, input logic [31:0] lat, input logic [63:0] nbytes);
    cmd_t c;
    c.command       = CMD_RECORD;
    c.event_kind    = kind[5:0];
    c.latency_ticks = lat;
    c.byte_count    = nbytes;
    issue(c);
  endtask

  task automatic report();
    cmd_t c;
    c.command       = CMD_REPORT;
    c.event_kind    = 6'($urandom_range(0, 63));
    c.latency_ticks = $urandom;
    c.byte_count    = {$urandom, $urandom};
    issue(c);
  endtask

  // block idle: every entry in, no record in flight, then a short pause
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (waiting != 0 || busy !== 1'b0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic configure(input int p);
    logic [31:0] val;
    logic        mode;
    int          i;
    settle();
    case (p)
      0, 2:    mode = 1'b1;
      1:       mode = 1'b0;
      default: mode = 1'($urandom_range(0, 1));
    endcase
    val = $urandom;
    reg_access(1'b1, REG_DETAILED_MODE, {val[31:1], mode});
    val = 32'd0;
    for (i = 0; i < NUM_BOUNDS; i++) begin
      case (p)
        0:       val = BOUND_RESET[i];
        1:       val = 32'd0;
        2:       val = 32'hFFFF_FFFF;
        default: begin
          if (p % 2 == 1) val = $urandom;
          else val = val + $urandom_range(0, 70000);
        end
      endcase
      reg_access(1'b1, REG_BOUND_0 + i, val);
    end
    if (p == 3) reg_access(1'b1, REG_SPARE, $urandom);
    for (i = REG_DETAILED_MODE; i <= REG_BOUND_5; i++) reg_access(1'b0, i, '0);
  endtask

  task automatic random_item();
    int          kind;
    logic [31:0] lat;
    logic [63:0] nbytes;
    if ($urandom_range(0, 11) == 0) begin
      report();
    end else begin
      case ($urandom_range(0, 9))
        0:       kind = $urandom_range(DEF_NUM_KINDS, 63);
        1:       kind = KIND_READ;
        2:       kind = KIND_WRITE;
        3:       kind = ($urandom_range(0, 1) == 0) ? 23 : 24;
        default: kind = $urandom_range(0, DEF_NUM_KINDS - 1);
      endcase
      case ($urandom_range(0, 5))
        0:       lat = 32'd0;
        1:       lat = 32'hFFFF_FFFF;
        2:       lat = $urandom_range(0, 1000);
        default: lat = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0:       nbytes = {32'd0, cur_bound[$urandom_range(0, NUM_BOUNDS - 1)]}
                          + 64'($urandom_range(0, 2)) - 64'd1;
        1:       nbytes = 64'd0;
        2:       nbytes = '1;
        3:       nbytes = 64'($urandom_range(0, 300000));
        default: nbytes = {$urandom, $urandom};
      endcase
      record(kind, lat, nbytes);
    end
  endtask

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || result_valid_o || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no traffic for %0d cycles, %0d entries still due", IDLE_LIMIT, waiting);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int p;
    int n;
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    cmd_i   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    calm = 1'b0;
    for (n = 0; n < NUM_BOUNDS; n++) cur_bound[n] = BOUND_RESET[n];
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset settings, summary mode
    report();                                       // empty bank
    record(KIND_READ, 32'd0, 64'd0);
    record(KIND_READ, 32'hFFFF_FFFF, '1);           // last read bucket
    record(KIND_READ, 32'd5, '1);                   // byte sum wraps
    record(KIND_WRITE, 32'd9, 64'd4095);
    record(KIND_WRITE, 32'd10, 64'd4096);           // size equal to a bound
    record(23, 32'd100, 64'd262143);                // child of read
    record(24, 32'd200, 64'd262144);                // child of write, last bucket
    record(5, 32'd1, 64'd1);
    record(11, 32'd2, 64'd1);
    record(25, 32'd3, 64'd1);
    record(35, 32'd4, 64'd1);                       // not shown in summary mode
    record(36, 32'd7, 64'd1);                       // unknown kinds
    record(63, 32'hFFFF_FFFF, '1);
    record(0, 32'd50, 64'd77);
    report();
    report();                                       // other bank, still empty
    record(35, 32'd7, 64'd3);
    record(22, 32'd8, 64'd5000);
    report();
    record(10, 32'd9, 64'd1);
    record(30, 32'hFFFF_FFFF, 64'd1);               // single all-ones latency
    report();

    for (p = 0; p < PHASES; p++) begin
      configure(p);
      calm = (p == PHASES - 1);
      for (n = 0; n < PHASE_ITEMS; n++) random_item();
      report();
    end

    settle();
    $display("covered %0d records, %0d reports, %0d streamed entries, %0d register writes",
             n_records, n_reports, n_entries, n_writes);
    if (errors == 0 && waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d entries never arrived", errors, waiting);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
